// File: rtl/core/zip_extra_field_locator_defines.svh
// Assertion macros for the extra-field locator.
`ifndef ZIP_EXTRA_FIELD_LOCATOR_DEFINES_SVH
`define ZIP_EXTRA_FIELD_LOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ZEL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ZEL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/zel_pkg.sv
// Shared types and constants for the extra-field locator.
`timescale 1ns / 1ps
`default_nettype none

package zel_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned POS_W  = 16;

  // Record header is id (2 bytes) then length (2 bytes)
  localparam logic [2:0] HDR_LEN = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_FOUND        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND    = 2'd1;
  localparam logic [1:0] ST_INCONSISTENT = 2'd2;

  // Register index, taken from paddr[2]
  localparam logic REG_FIELD_ID   = 1'b0;
  localparam logic REG_OCCURRENCE = 1'b1;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  typedef struct packed {
    logic [ID_W-1:0] field_id;
    logic [ID_W-1:0] occurrence;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] data_offset;
    logic [POS_W-1:0] data_length;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/zel_cfg.sv
// APB register file: field id and occurrence.
`timescale 1ns / 1ps
`default_nettype none

module zel_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [zel_pkg::PADDR_W-1:0] paddr,
  input  wire logic [zel_pkg::PDATA_W-1:0] pwdata,
  output logic      [zel_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  output zel_pkg::cfg_t                    cfg
);
  import zel_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_FIELD_ID:   cfg.field_id   <= pwdata[ID_W-1:0];
        REG_OCCURRENCE: cfg.occurrence <= pwdata[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // Low address bits are don't-care
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_FIELD_ID:   prdata = {{(PDATA_W-ID_W){1'b0}}, cfg.field_id};
      REG_OCCURRENCE: prdata = {{(PDATA_W-ID_W){1'b0}}, cfg.occurrence};
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/zel_scan.sv
// Record walker: header tracking, match counting and result forming.
`timescale 1ns / 1ps
`default_nettype none

module zel_scan (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_fire,
  input  wire logic [zel_pkg::BYTE_W-1:0] data_byte,
  input  wire logic                       last_byte,
  input  wire zel_pkg::cfg_t              cfg,
  output logic                            res_valid,
  output zel_pkg::res_t                   res
);
  import zel_pkg::*;

  logic [2:0]          header_count,      header_count_next;
  logic [3*BYTE_W-1:0] header_bytes,      header_bytes_next;
  logic [POS_W-1:0]    data_remaining,    data_remaining_next;
  logic [POS_W-1:0]    byte_position,     byte_position_next;
  logic [ID_W-1:0]     match_count,       match_count_next;
  logic                candidate_pending, candidate_pending_next;
  logic                search_done,       search_done_next;
  logic [POS_W-1:0]    found_offset,      found_offset_next;
  logic [POS_W-1:0]    found_length,      found_length_next;

  logic [POS_W-1:0] rec_len;
  logic [ID_W-1:0]  rec_id;

  assign rec_id  = header_bytes[ID_W-1:0];
  assign rec_len = {data_byte, header_bytes[3*BYTE_W-1:2*BYTE_W]};

  always_comb begin
    header_count_next      = header_count;
    header_bytes_next      = header_bytes;
    data_remaining_next    = data_remaining;
    byte_position_next     = byte_position;
    match_count_next       = match_count;
    candidate_pending_next = candidate_pending;
    search_done_next       = search_done;
    found_offset_next      = found_offset;
    found_length_next      = found_length;
    res_valid              = 1'b0;
    res                    = '0;

    if (in_fire) begin
      if (!search_done) begin
        byte_position_next = byte_position + 1'b1;
        if (header_count < HDR_LEN - 3'd1) begin
          header_bytes_next[{header_count[1:0], 3'b000} +: BYTE_W] = data_byte;
          header_count_next = header_count + 3'd1;
        end else if (header_count == HDR_LEN - 3'd1) begin
          // header complete
          header_count_next   = HDR_LEN;
          header_bytes_next   = '0;
          data_remaining_next = rec_len;
          if (rec_id == cfg.field_id) begin
            if (match_count < cfg.occurrence) begin
              match_count_next = match_count + 1'b1;
            end else begin
              candidate_pending_next = 1'b1;
              found_offset_next      = byte_position + 1'b1;
              found_length_next      = rec_len;
            end
          end
          if (rec_len == '0) begin
            header_count_next = '0;
            if (candidate_pending_next) begin
              candidate_pending_next = 1'b0;
              search_done_next       = 1'b1;
            end
          end
        end else begin
          // data byte of current record
          data_remaining_next = data_remaining - 1'b1;
          if (data_remaining_next == '0) begin
            header_count_next = '0;
            if (candidate_pending) begin
              candidate_pending_next = 1'b0;
              search_done_next       = 1'b1;
            end
          end
        end
      end

      if (last_byte) begin
        res_valid = 1'b1;
        if (search_done_next) begin
          res.status      = ST_FOUND;
          res.data_offset = found_offset_next;
          res.data_length = found_length_next;
        end else if (header_count_next == '0 && !candidate_pending_next) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.status = ST_INCONSISTENT;
        end
        // back to search start for the next area
        header_count_next      = '0;
        header_bytes_next      = '0;
        data_remaining_next    = '0;
        byte_position_next     = '0;
        match_count_next       = '0;
        candidate_pending_next = 1'b0;
        search_done_next       = 1'b0;
        found_offset_next      = '0;
        found_length_next      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count      <= '0;
      header_bytes      <= '0;
      data_remaining    <= '0;
      byte_position     <= '0;
      match_count       <= '0;
      candidate_pending <= 1'b0;
      search_done       <= 1'b0;
      found_offset      <= '0;
      found_length      <= '0;
    end else begin
      header_count      <= header_count_next;
      header_bytes      <= header_bytes_next;
      data_remaining    <= data_remaining_next;
      byte_position     <= byte_position_next;
      match_count       <= match_count_next;
      candidate_pending <= candidate_pending_next;
      search_done       <= search_done_next;
      found_offset      <= found_offset_next;
      found_length      <= found_length_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/zel_out.sv
// Result register with valid/stall handshake.
`timescale 1ns / 1ps
`default_nettype none

module zel_out (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   res_valid,
  input  wire zel_pkg::res_t res,
  input  wire logic   out_stall,
  output logic        out_valid,
  output zel_pkg::res_t out_res
);
  import zel_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Loaded only when the register is free or being drained
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/zip_extra_field_locator.sv
// Top level of the ZIP extra-field record locator.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------
//  in      | in  | in_valid / in_stall  | data_byte[7:0], last_byte
//  out     | out | out_valid / out_stall| status[1:0], data_offset, data_length
//  cfg     | in  | APB psel/penable     | field_id @0x0, occurrence @0x4
//
//  One byte is taken per cycle unless stalled; the record walker updates its
//  counters in the same cycle and a result item appears in the cycle after the
//  last byte. The result register is the only stage: non-last bytes are taken
//  even while a result is stalled; a last byte waits only while the result
//  register is full and stalled. Synchronous reset clears all control
//  state and both registers (field_id, occurrence) to zero.
`timescale 1ns / 1ps
`default_nettype none
`include "zip_extra_field_locator_defines.svh"

module zip_extra_field_locator (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // byte input
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [zel_pkg::BYTE_W-1:0]  data_byte,
  input  wire logic                        last_byte,
  // result output
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [1:0]                  status,
  output logic      [zel_pkg::POS_W-1:0]   data_offset,
  output logic      [zel_pkg::POS_W-1:0]   data_length,
  // register port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [zel_pkg::PADDR_W-1:0] paddr,
  input  wire logic [zel_pkg::PDATA_W-1:0] pwdata,
  output logic      [zel_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);
  import zel_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_res;
  logic res_valid;
  logic in_fire;

  // Only a result-producing byte can collide with a held result
  assign in_stall = out_valid & out_stall & last_byte;
  assign in_fire  = in_valid & ~in_stall;

  zel_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  zel_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  zel_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign status      = out_res.status;
  assign data_offset = out_res.data_offset;
  assign data_length = out_res.data_length;

  `ZEL_ASSERT_NEXT(a_last_gives_result, in_fire && last_byte, out_valid, "last byte lost result")
  `ZEL_ASSERT_NEXT(a_no_spurious_result, in_fire && !last_byte && !out_valid, !out_valid, "result without last byte")
  `ZEL_ASSERT_NOW(a_miss_zero_fields, out_valid && status != ST_FOUND, data_offset == '0 && data_length == '0, "nonzero fields on miss")
  `ZEL_ASSERT_NOW(a_status_legal, out_valid, status == ST_FOUND || status == ST_NOT_FOUND || status == ST_INCONSISTENT, "illegal status")

endmodule

`default_nettype wire
